// File: rtl/core/tre_pkg.sv
// Shared constants, state type and entry-word field helpers for the TLB register engine.
package tre_pkg;

  localparam int ENTRIES    = 32;
  localparam int VPAGE_BITS = 12;
  localparam int PPAGE_BITS = 8;
  localparam int ACC_BITS   = 3;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // Field positions inside the packed 32-bit entry word, counted from bit 0.
  localparam int VP_LSB  = 8;
  localparam int PP_LSB  = VP_LSB + VPAGE_BITS;
  localparam int AC_LSB  = PP_LSB + PPAGE_BITS;
  localparam int ACT_LSB = AC_LSB + ACC_BITS;

  localparam logic [63:0] VP_MASK  = ((64'd1 << VPAGE_BITS) - 64'd1) << VP_LSB;
  localparam logic [63:0] PP_MASK  = ((64'd1 << PPAGE_BITS) - 64'd1) << PP_LSB;
  localparam logic [63:0] AC_MASK  = ((64'd1 << ACC_BITS) - 64'd1) << AC_LSB;
  localparam logic [63:0] ACT_MASK = 64'd1 << ACT_LSB;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_WRITE  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_REQ,
    ST_RD_DATA,
    ST_WR_REQ,
    ST_WR_DATA,
    ST_UNLINK,
    ST_STORE,
    ST_LINK,
    ST_LOAD,
    ST_MODIFY,
    ST_DONE
  } state_t;

  // Fields that would reach past bit 31 read as zero.
  function automatic logic [VPAGE_BITS-1:0] get_vp(input logic [31:0] w);
    logic [63:0] v;
    v = {32'd0, w} >> VP_LSB;
    return v[VPAGE_BITS-1:0];
  endfunction

  function automatic logic [PPAGE_BITS-1:0] get_pp(input logic [31:0] w);
    logic [63:0] v;
    v = {32'd0, w} >> PP_LSB;
    return v[PPAGE_BITS-1:0];
  endfunction

  function automatic logic entry_live(input logic [31:0] w);
    logic [63:0] v;
    v = {32'd0, w} & ACT_MASK;
    return (v != 64'd0);
  endfunction

  function automatic logic [31:0] clear_active(input logic [31:0] w);
    logic [63:0] v;
    v = {32'd0, w} & ~ACT_MASK;
    return v[31:0];
  endfunction

  // Merges page and access fields of src into old and sets the active bit.
  function automatic logic [31:0] merge_entry(input logic [31:0] old, input logic [31:0] src);
    logic [63:0] o;
    logic [63:0] s;
    logic [63:0] m;
    logic [63:0] x;
    o = {32'd0, old};
    s = {32'd0, src};
    m = VP_MASK | PP_MASK | AC_MASK;
    x = (o & ~m) | (s & m) | ACT_MASK;
    return x[31:0];
  endfunction

endpackage

// File: rtl/core/tlb_register_engine_top.sv
// Top level of the TLB register engine: command sequencer, entry memory and scan compare.
//
// The block holds a fully associative table of ENTRIES packed entry words. A command is
// transferred when start is high and busy is low; mode, entry_index and data_word are
// sampled at that edge. Add mode links a virtual page (reusing a matching active entry,
// else the lowest inactive one, else the round-robin victim). Delete mode clears every
// active entry whose physical page matches. Read mode returns the raw word at an index.
// Write mode unlinks the old physical page at the index, stores the raw word and then
// links its fields.
//
// Every command produces exactly one result transfer: done is high for one cycle and
// read_data carries the word (zero for every mode except read). The receiver cannot
// stall, so the result is simply presented for that single cycle.
//
// The entry memory has one read port and one write port, and one compare unit walks it one
// entry per cycle. Read needs no scan, delete one unlink scan, add one link scan, and write
// an unlink scan followed by a link scan.
// busy stays high for the whole command and drops in the cycle after done.
//
// Synchronous reset empties the table at once through per-entry valid flags (an entry
// never written reads as zero) and returns the victim pointer to entry zero.
module tlb_register_engine_top
  import tre_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [4:0]  entry_index,
  input  logic [31:0] data_word,
  output logic        done,
  output logic [31:0] read_data
);

  state_t state;
  state_t state_next;

  // Command registers captured at the input transfer.
  logic [1:0]            mode_q;
  logic [4:0]            index_q;
  logic [31:0]           data_q;
  logic [PPAGE_BITS-1:0] pp_key;

  // Scan counter: reads entry cnt while comparing entry cnt - 1.
  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] cmp_idx;
  logic             cmp_en;
  logic             scan_end;

  // Link search results.
  logic             vp_hit;
  logic [IDX_W-1:0] vp_sel;
  logic             free_hit;
  logic [IDX_W-1:0] free_sel;
  logic [IDX_W-1:0] sel;
  logic [IDX_W-1:0] victim;
  logic [31:0]      result;

  // Search results including the entry compared in the current cycle.
  logic             link_vp_hit;
  logic [IDX_W-1:0] link_vp_sel;
  logic             link_free_hit;
  logic [IDX_W-1:0] link_free_sel;

  // Entry memory with per-entry valid flags standing in for the cleared reset value.
  logic [31:0]        mem [ENTRIES];
  logic [ENTRIES-1:0] entry_valid;
  logic [31:0]        rd_data;
  logic               rd_valid;
  logic [31:0]        rd_word;
  logic [IDX_W-1:0]   mem_raddr;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [31:0]        mem_wdata;

  logic index_ok;
  logic unlink_hit;
  logic vp_match;

  assign index_ok   = (int'(index_q) < ENTRIES);
  assign cmp_idx    = IDX_W'(cnt - CNT_W'(1));
  assign cmp_en     = (cnt != '0);
  assign scan_end   = (cnt == CNT_W'(ENTRIES));
  assign rd_word    = rd_valid ? rd_data : 32'd0;
  assign unlink_hit = entry_live(rd_word) && (get_pp(rd_word) == pp_key);
  assign vp_match   = entry_live(rd_word) && (get_vp(rd_word) == get_vp(data_q));

  // The last entry is compared in the scan_end cycle, so the final choice folds it in here.
  assign link_vp_hit   = vp_hit || (cmp_en && vp_match);
  assign link_vp_sel   = vp_hit ? vp_sel : cmp_idx;
  assign link_free_hit = free_hit || (cmp_en && !entry_live(rd_word));
  assign link_free_sel = free_hit ? free_sel : cmp_idx;

  assign busy      = (state != ST_IDLE);
  assign done      = (state == ST_DONE);
  assign read_data = result;

  // Next-state logic of the command sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (mode)
            MODE_ADD:    state_next = ST_LINK;
            MODE_DELETE: state_next = ST_UNLINK;
            MODE_READ:   state_next = (int'(entry_index) < ENTRIES) ? ST_RD_REQ : ST_DONE;
            default:     state_next = (int'(entry_index) < ENTRIES) ? ST_WR_REQ : ST_DONE;
          endcase
        end
      end
      ST_RD_REQ:  state_next = ST_RD_DATA;
      ST_RD_DATA: state_next = ST_DONE;
      ST_WR_REQ:  state_next = ST_WR_DATA;
      ST_WR_DATA: state_next = ST_UNLINK;
      ST_UNLINK: begin
        if (scan_end) begin
          state_next = (mode_q == MODE_WRITE) ? ST_STORE : ST_DONE;
        end
      end
      ST_STORE: state_next = ST_LINK;
      ST_LINK: begin
        if (scan_end) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD:   state_next = ST_MODIFY;
      ST_MODIFY: state_next = ST_DONE;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Memory port control for each sequencer state.
  always_comb begin
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = 32'd0;
    case (state)
      ST_RD_REQ, ST_WR_REQ: begin
        mem_raddr = IDX_W'(index_q);
      end
      ST_UNLINK: begin
        mem_raddr = IDX_W'(cnt);
        if (cmp_en && unlink_hit) begin
          mem_we    = 1'b1;
          mem_waddr = cmp_idx;
          mem_wdata = clear_active(rd_word);
        end
      end
      ST_STORE: begin
        mem_we    = 1'b1;
        mem_waddr = IDX_W'(index_q);
        mem_wdata = data_q;
      end
      ST_LINK: begin
        mem_raddr = IDX_W'(cnt);
      end
      ST_LOAD: begin
        mem_raddr = sel;
      end
      ST_MODIFY: begin
        mem_we    = 1'b1;
        mem_waddr = sel;
        mem_wdata = merge_entry(rd_word, data_q);
      end
      default: begin
        mem_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data  <= mem[mem_raddr];
    rd_valid <= entry_valid[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (mem_we) begin
      entry_valid[mem_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cnt    <= '0;
      victim <= '0;
    end else begin
      state <= state_next;
      if ((state == ST_UNLINK || state == ST_LINK) && !scan_end) begin
        cnt <= cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
      if (state == ST_LINK && scan_end && !link_vp_hit && !link_free_hit) begin
        victim <= (victim == IDX_W'(ENTRIES - 1)) ? '0 : victim + IDX_W'(1);
      end
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          mode_q  <= mode;
          index_q <= entry_index;
          data_q  <= data_word;
          pp_key  <= get_pp(data_word);
          result  <= 32'd0;
        end
      end
      ST_RD_DATA: begin
        result <= rd_word;
      end
      ST_WR_DATA: begin
        pp_key <= get_pp(rd_word);
      end
      ST_LINK: begin
        if (!cmp_en) begin
          vp_hit   <= 1'b0;
          free_hit <= 1'b0;
        end else begin
          if (!vp_hit && vp_match) begin
            vp_hit <= 1'b1;
            vp_sel <= cmp_idx;
          end
          if (!free_hit && !entry_live(rd_word)) begin
            free_hit <= 1'b1;
            free_sel <= cmp_idx;
          end
        end
        if (scan_end) begin
          // Matching virtual page wins, then the lowest free entry, then the victim.
          if (link_vp_hit) begin
            sel <= link_vp_sel;
          end else if (link_free_hit) begin
            sel <= link_free_sel;
          end else begin
            sel <= victim;
          end
        end
      end
      default: begin
        result <= result;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a command in flight");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command accepted but sequencer did not start");

  a_victim_range: assert property (@(posedge clk) disable iff (rst)
    int'(victim) < ENTRIES)
    else $error("victim pointer outside the table");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    int'(cnt) <= ENTRIES)
    else $error("scan counter ran past the table");

  a_store_in_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STORE) |-> (mode_q == MODE_WRITE) && index_ok)
    else $error("raw store outside a valid write command");
`endif

endmodule

// File: tb/tb_tlb_register_engine_top.sv
// Self-checking testbench for the TLB register engine, predicting every result from a shadow table.
module tb_tlb_register_engine_top;
  import tre_pkg::*;

  // One command as the driver presents it, plus the idle cycles that follow its transfer
  // and a flag that makes the driver wait for every outstanding result first.
  typedef struct {
    logic [1:0]  mode;
    logic [4:0]  idx;
    logic [31:0] word;
    int          gap;
    bit          drain;
  } tlb_cmd_t;

  // Every input is driven to a known value from time zero.
  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        start       = 1'b0;
  logic [1:0]  mode        = MODE_ADD;
  logic [4:0]  entry_index = '0;
  logic [31:0] data_word   = '0;
  logic        busy;
  logic        done;
  logic [31:0] read_data;

  tlb_cmd_t    pending_cmds[$];
  logic [31:0] expected_words[$];

  // Shadow copy of the entry table and of the round-robin victim pointer.
  logic [31:0] shadow_entries [ENTRIES];
  int          shadow_victim;

  int          total_cmds   = 0;
  int          sent_cnt     = 0;
  int          got_cnt      = 0;
  int          hold_off     = 0;
  int          mismatch_cnt = 0;

  tlb_register_engine_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .entry_index (entry_index),
    .data_word   (data_word),
    .done        (done),
    .read_data   (read_data)
  );

  // Free-running clock with a period of four time units.
  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------------------
  // Shadow table. These routines mirror what the engine does to its entry memory, one
  // command at a time, in the order the commands are transferred.
  // ---------------------------------------------------------------------------------------

  // Clears the active bit of every active entry that maps the given physical page.
  task automatic shadow_unlink_ppage(input logic [PPAGE_BITS-1:0] ppage);
    for (int i = 0; i < ENTRIES; i++) begin
      if (shadow_entries[i][ACT_LSB] && shadow_entries[i][PP_LSB +: PPAGE_BITS] == ppage)
        shadow_entries[i][ACT_LSB] = 1'b0;
    end
  endtask

  // Links a virtual page. An active entry with the same virtual page wins over everything;
  // failing that the lowest inactive entry is used; a full table evicts the victim entry.
  task automatic shadow_link_vpage(input logic [VPAGE_BITS-1:0] vpage,
                                   input logic [PPAGE_BITS-1:0] ppage,
                                   input logic [ACC_BITS-1:0]   access);
    int          sel;
    bit          found;
    logic [31:0] w;
    sel   = 0;
    found = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (shadow_entries[i][ACT_LSB] && shadow_entries[i][VP_LSB +: VPAGE_BITS] == vpage) begin
        sel   = i;
        found = 1'b1;
        break;
      end
      if (!found && !shadow_entries[i][ACT_LSB]) begin
        sel   = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      sel           = shadow_victim;
      shadow_victim = (shadow_victim == ENTRIES - 1) ? 0 : shadow_victim + 1;
    end
    // Bits outside the page, access and active fields keep their old contents.
    w                          = shadow_entries[sel];
    w[VP_LSB +: VPAGE_BITS]    = vpage;
    w[PP_LSB +: PPAGE_BITS]    = ppage;
    w[AC_LSB +: ACC_BITS]      = access;
    w[ACT_LSB]                 = 1'b1;
    shadow_entries[sel]        = w;
  endtask

  // Applies one command to the shadow table and returns the word the engine must report.
  task automatic shadow_command(input  logic [1:0]  cmd_mode,
                                input  logic [4:0]  cmd_idx,
                                input  logic [31:0] cmd_word,
                                output logic [31:0] reply);
    reply = '0;
    case (cmd_mode)
      MODE_ADD: begin
        shadow_link_vpage(cmd_word[VP_LSB +: VPAGE_BITS], cmd_word[PP_LSB +: PPAGE_BITS],
                          cmd_word[AC_LSB +: ACC_BITS]);
      end
      MODE_DELETE: begin
        shadow_unlink_ppage(cmd_word[PP_LSB +: PPAGE_BITS]);
      end
      MODE_READ: begin
        if (cmd_idx < ENTRIES)
          reply = shadow_entries[cmd_idx];
      end
      default: begin
        // A write to an index past the table has no effect at all.
        if (cmd_idx < ENTRIES) begin
          shadow_unlink_ppage(shadow_entries[cmd_idx][PP_LSB +: PPAGE_BITS]);
          shadow_entries[cmd_idx] = cmd_word;
          shadow_link_vpage(cmd_word[VP_LSB +: VPAGE_BITS], cmd_word[PP_LSB +: PPAGE_BITS],
                            cmd_word[AC_LSB +: ACC_BITS]);
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------------------

  // Packs an entry word from its fields.
  function automatic logic [31:0] pack_entry(input int vpage, input int ppage, input int access,
                                             input bit active, input logic [7:0] spare);
    logic [31:0] w;
    w                       = '0;
    w[VP_LSB-1:0]           = spare;
    w[VP_LSB +: VPAGE_BITS] = VPAGE_BITS'(vpage);
    w[PP_LSB +: PPAGE_BITS] = PPAGE_BITS'(ppage);
    w[AC_LSB +: ACC_BITS]   = ACC_BITS'(access);
    w[ACT_LSB]              = active;
    return w;
  endfunction

  // Most gaps are zero or short, a few are long enough to span a whole write command.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 4);
    else
      return $urandom_range(10, 100);
  endfunction

  // Physical pages come mostly from a small pool so that deletes and unlinks hit entries.
  function automatic int pick_ppage();
    if ($urandom_range(0, 3) == 0)
      return $urandom_range(0, (1 << PPAGE_BITS) - 1);
    else
      return $urandom_range(0, 15);
  endfunction

  // Virtual pages are mostly fresh so the table fills up, sometimes from a tiny pool so
  // that an add reuses the entry already mapping that page.
  function automatic int pick_vpage();
    if ($urandom_range(0, 3) == 0)
      return $urandom_range(0, 7);
    else
      return $urandom_range(0, (1 << VPAGE_BITS) - 1);
  endfunction

  // Random word whose page fields are drawn from the pools above.
  function automatic logic [31:0] random_entry();
    logic [31:0] w;
    w                       = $urandom;
    w[VP_LSB +: VPAGE_BITS] = VPAGE_BITS'(pick_vpage());
    w[PP_LSB +: PPAGE_BITS] = PPAGE_BITS'(pick_ppage());
    return w;
  endfunction

  // Appends a command. A stretch in the random part runs with no gaps at all, and every
  // so often the driver holds off until the engine has reported everything it owes.
  task automatic queue_cmd(input logic [1:0] cmd_mode, input int cmd_idx,
                           input logic [31:0] cmd_word);
    tlb_cmd_t cmd;
    int       pos;
    pos       = pending_cmds.size();
    cmd.mode  = cmd_mode;
    cmd.idx   = 5'(cmd_idx);
    cmd.word  = cmd_word;
    cmd.gap   = (pos >= 170 && pos < 230) ? 0 : pick_gap();
    cmd.drain = (pos % 128) == 100;
    pending_cmds.push_back(cmd);
  endtask

  // ---------------------------------------------------------------------------------------
  // Driver. A transfer happens at a rising edge where start is high and busy is low. At that
  // edge the command is applied to the shadow table and its expected reply is queued. The
  // next command is presented once the gap that follows the transfer has run out.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin : cmd_driver
    logic [31:0] reply;
    int          in_flight;
    tlb_cmd_t    cmd;
    if (rst) begin
      start    <= 1'b0;
      hold_off <= 0;
    end else begin
      in_flight = sent_cnt - got_cnt;
      if (start && !busy) begin
        shadow_command(mode, entry_index, data_word, reply);
        expected_words.push_back(reply);
        sent_cnt  <= sent_cnt + 1;
        in_flight = in_flight + 1;
      end
      // With start high and busy high the command simply stays on the ports.
      if (!start || !busy) begin
        if (hold_off > 0) begin
          start    <= 1'b0;
          hold_off <= hold_off - 1;
        end else if (pending_cmds.size() != 0 &&
                     (!pending_cmds[0].drain || in_flight == 0)) begin
          cmd         = pending_cmds.pop_front();
          start       <= 1'b1;
          mode        <= cmd.mode;
          entry_index <= cmd.idx;
          data_word   <= cmd.word;
          hold_off    <= cmd.gap;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor. The engine cannot be stalled, so every cycle with done high is a result
  // transfer; it is checked against the oldest expected reply.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    logic [31:0] want;
    if (!rst && done) begin
      got_cnt <= got_cnt + 1;
      if (expected_words.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result %0d: read_data %h with no command outstanding",
                   got_cnt, read_data);
      end else begin
        want = expected_words.pop_front();
        if (read_data !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result %0d: read_data expected %h, got %h", got_cnt, want, read_data);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------------------
  initial begin : stimulus
    int n;
    int burst;
    int pick;
    for (int i = 0; i < ENTRIES; i++)
      shadow_entries[i] = '0;
    shadow_victim = 0;

    // Directed part. Reads of an empty table at both ends of the index range.
    queue_cmd(MODE_READ, 0, '0);
    queue_cmd(MODE_READ, ENTRIES - 1, 32'hFFFF_FFFF);
    // Adds with all-zero and all-one fields; the spare bits of the word must not land.
    queue_cmd(MODE_ADD, 31, pack_entry(0, 0, 0, 1'b0, 8'hFF));
    queue_cmd(MODE_ADD, 0, pack_entry(12'hFFF, 8'hFF, 7, 1'b1, 8'hFF));
    // Same virtual page again: the entry already mapping it is reused.
    queue_cmd(MODE_ADD, 7, pack_entry(0, 8'h55, 5, 1'b0, 8'h00));
    queue_cmd(MODE_READ, 0, '0);
    queue_cmd(MODE_READ, 1, '0);
    // Write of an inactive word: the store keeps it raw, the following add picks entry 2.
    queue_cmd(MODE_WRITE, 5, pack_entry(12'h123, 8'h55, 3, 1'b0, 8'hA5));
    queue_cmd(MODE_READ, 5, '0);
    queue_cmd(MODE_READ, 2, '0);
    // Write of an active word: the add finds the stored entry itself.
    queue_cmd(MODE_WRITE, 3, pack_entry(12'h777, 8'h10, 1, 1'b1, 8'h3C));
    // Write of an inactive word where the written entry is the lowest free one.
    queue_cmd(MODE_WRITE, 4, pack_entry(12'h999, 8'h20, 6, 1'b0, 8'h00));
    queue_cmd(MODE_READ, 3, '0);
    queue_cmd(MODE_READ, 4, '0);
    // Delete that hits two active entries sharing a physical page.
    queue_cmd(MODE_DELETE, 9, pack_entry(0, 8'h55, 0, 1'b0, 8'h00));
    queue_cmd(MODE_READ, 0, '0);
    queue_cmd(MODE_READ, 2, '0);
    // Write of an all-ones word over an active entry: unlink of its old page first.
    queue_cmd(MODE_WRITE, 1, 32'hFFFF_FFFF);
    queue_cmd(MODE_READ, 1, '0);
    queue_cmd(MODE_WRITE, ENTRIES - 1, 32'h0000_0000);
    queue_cmd(MODE_READ, ENTRIES - 1, '0);
    queue_cmd(MODE_DELETE, 0, 32'hFFFF_FFFF);
    queue_cmd(MODE_READ, 1, '0);

    // Random part. Bursts of adds fill the table and drive the round-robin victim pointer
    // around; single commands of every mode mix in deletes, writes and reads.
    n = 0;
    while (n < 400) begin
      if ($urandom_range(0, 9) < 3) begin
        burst = $urandom_range(8, 40);
        repeat (burst) begin
          queue_cmd(MODE_ADD, $urandom_range(0, 31), random_entry());
          n++;
        end
        queue_cmd(MODE_READ, $urandom_range(0, 31), $urandom);
        n++;
      end else begin
        pick = $urandom_range(0, 3);
        case (pick)
          0:       queue_cmd(MODE_ADD, $urandom_range(0, 31), random_entry());
          1:       queue_cmd(MODE_DELETE, $urandom_range(0, 31), random_entry());
          2:       queue_cmd(MODE_READ, $urandom_range(0, 31), $urandom);
          default: queue_cmd(MODE_WRITE, $urandom_range(0, 31), random_entry());
        endcase
        n++;
      end
    end
    total_cmds = pending_cmds.size();

    // Synchronous reset is held from time zero and released at a rising edge.
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Wait until every command has been transferred and answered, then let a full write
    // command's worth of cycles pass so that a stray late result would still be caught.
    do @(posedge clk); while (sent_cnt != total_cmds || got_cnt != sent_cnt);
    repeat (2 * ENTRIES + 16) @(posedge clk);

    if (expected_words.size() != 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("%0d expected results never arrived", expected_words.size());
    end
    if (mismatch_cnt == 0) begin
      $display("PASS tlb_register_engine_top");
    end else begin
      $display("FAIL tlb_register_engine_top");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run of every command at its longest latency
  // followed by its longest gap.
  initial begin : watchdog
    #4000000;
    $display("FAIL tlb_register_engine_top");
    $finish;
  end

endmodule

// File: files.f
rtl/core/tre_pkg.sv
rtl/core/tlb_register_engine_top.sv
tb/tb_tlb_register_engine_top.sv
